// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while in reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tcf_pkg.sv =====
// Shared types, constants and the CORDIC angle table for the tilt filter.
// No dependencies.
package tcf_pkg;

	localparam int unsigned CORDIC_STEPS_DEF = 16;
	localparam int unsigned IN_W = 16;
	localparam int unsigned ANGLE_W = 24;
	localparam int unsigned CFG_W = 16;
	localparam int unsigned CORDIC_W = 35;
	localparam int unsigned Z_W = 27;
	localparam int unsigned RD_W = 33;
	localparam int unsigned TAB_LEN = 24;
	localparam int unsigned TAB_IW = 5;

	localparam logic signed [Z_W-1:0] Z_PLUS_90 = Z_W'(90 * 65536);
	localparam logic signed [Z_W-1:0] Z_MINUS_90 = -Z_W'(90 * 65536);
	localparam logic [CFG_W-1:0] BLEND_WEIGHT_RST = CFG_W'(64225);
	localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST = CFG_W'(655);

	localparam logic [0:0] REG_BLEND_WEIGHT = 1'b0;
	localparam logic [0:0] REG_SAMPLE_PERIOD = 1'b1;

	typedef struct packed {
		logic signed [IN_W-1:0] accel_x;
		logic signed [IN_W-1:0] accel_y;
		logic signed [IN_W-1:0] accel_z;
		logic signed [IN_W-1:0] gyro_x;
		logic signed [IN_W-1:0] gyro_y;
	} sample_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] pitch_out;
		logic signed [ANGLE_W-1:0] roll_out;
	} angles_t;

	typedef struct packed {
		logic [CFG_W-1:0] weight;
		logic [CFG_W-1:0] period;
	} lane_cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} fsm_state_t;

	// atan(2^-i) in 1/65536 degree
	function automatic logic signed [Z_W-1:0] atan_tab(input logic [TAB_IW-1:0] idx);
		logic signed [Z_W-1:0] v;
		unique case (idx)
			5'd0:  v = Z_W'(2949120);
			5'd1:  v = Z_W'(1740967);
			5'd2:  v = Z_W'(919879);
			5'd3:  v = Z_W'(466945);
			5'd4:  v = Z_W'(234379);
			5'd5:  v = Z_W'(117304);
			5'd6:  v = Z_W'(58666);
			5'd7:  v = Z_W'(29335);
			5'd8:  v = Z_W'(14668);
			5'd9:  v = Z_W'(7334);
			5'd10: v = Z_W'(3667);
			5'd11: v = Z_W'(1833);
			5'd12: v = Z_W'(917);
			5'd13: v = Z_W'(458);
			5'd14: v = Z_W'(229);
			5'd15: v = Z_W'(115);
			5'd16: v = Z_W'(57);
			5'd17: v = Z_W'(29);
			5'd18: v = Z_W'(14);
			5'd19: v = Z_W'(7);
			5'd20: v = Z_W'(4);
			5'd21: v = Z_W'(2);
			5'd22: v = Z_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/tilt_complementary_filter.sv =====
// Tilt complementary filter: pitch and roll lanes run side by side, results merge into one item.
// From the accepting edge to angle_valid an item passes a load step, the one-step-per-cycle CORDIC loop,
// three blend stages and the output register.
// One item in flight: a new item is taken only after the last result is loaded into the output register.
// The next item is taken while a finished result waits in the output register.
// Reset clears both angles to zero and loads alpha 64225 and dt 655; no clearing pass.
module tilt_complementary_filter #(
	parameter int unsigned CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  tcf_pkg::sample_t           sample,
	output logic                       angle_valid,
	input  logic                       angle_ready,
	output tcf_pkg::angles_t           angles,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_addr,
	input  logic [tcf_pkg::CFG_W-1:0]  cfg_wdata
);
	tcf_pkg::fsm_state_t state_q, state_nx;
	tcf_pkg::lane_cfg_t  cfg_q;
	tcf_pkg::angles_t    angles_q;
	logic                angle_valid_q;
	logic                start, load_out, out_free, lanes_done;
	logic                pitch_done, roll_done;
	logic signed [tcf_pkg::ANGLE_W-1:0] pitch_ang, roll_ang;
	logic signed [tcf_pkg::IN_W:0]      pitch_num, roll_num;

	assign pitch_num  = -$signed({sample.accel_x[tcf_pkg::IN_W-1], sample.accel_x});
	assign roll_num   = $signed({sample.accel_y[tcf_pkg::IN_W-1], sample.accel_y});
	assign lanes_done = pitch_done & roll_done;
	assign out_free   = !angle_valid_q || angle_ready;

	always_comb begin
		state_nx     = state_q;
		sample_ready = 1'b0;
		start        = 1'b0;
		load_out     = 1'b0;
		unique case (state_q)
			tcf_pkg::ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					start    = 1'b1;
					state_nx = tcf_pkg::ST_RUN;
				end
			end
			tcf_pkg::ST_RUN: begin
				if (lanes_done) begin
					if (out_free) begin
						load_out = 1'b1;
						state_nx = tcf_pkg::ST_IDLE;
					end else begin
						state_nx = tcf_pkg::ST_HOLD;
					end
				end
			end
			tcf_pkg::ST_HOLD: begin
				if (out_free) begin
					load_out = 1'b1;
					state_nx = tcf_pkg::ST_IDLE;
				end
			end
			default: state_nx = tcf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcf_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.weight <= tcf_pkg::BLEND_WEIGHT_RST;
			cfg_q.period <= tcf_pkg::SAMPLE_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				tcf_pkg::REG_BLEND_WEIGHT:  cfg_q.weight <= cfg_wdata;
				tcf_pkg::REG_SAMPLE_PERIOD: cfg_q.period <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_valid_q <= 1'b0;
		end else if (load_out) begin
			angle_valid_q <= 1'b1;
		end else if (angle_ready) begin
			angle_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			angles_q.pitch_out <= pitch_ang;
			angles_q.roll_out  <= roll_ang;
		end
	end

	tcf_lane #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_pitch (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.num   (pitch_num),
		.den   (sample.accel_z),
		.rate  (sample.gyro_y),
		.cfg   (cfg_q),
		.done  (pitch_done),
		.angle (pitch_ang)
	);

	tcf_lane #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_roll (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.num   (roll_num),
		.den   (sample.accel_z),
		.rate  (sample.gyro_x),
		.cfg   (cfg_q),
		.done  (roll_done),
		.angle (roll_ang)
	);

	assign angle_valid = angle_valid_q;
	assign angles      = angles_q;

endmodule

// ===== rtl/tcf_cordic.sv =====
// Iterative vectoring CORDIC: atan2(y, x) in 1/65536 degree, one step per cycle.
// Uses tcf_pkg for widths and the angle table.
module tcf_cordic #(
	parameter int unsigned CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [tcf_pkg::IN_W:0]     y_in,
	input  logic signed [tcf_pkg::IN_W-1:0]   x_in,
	output logic                              done,
	output logic signed [tcf_pkg::Z_W-1:0]    z_out
);
	localparam int unsigned CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam logic [CW-1:0] LAST = CW'(CORDIC_STEPS - 1);
	localparam int unsigned W = tcf_pkg::CORDIC_W;

	logic                             busy_q, done_q, zero_q;
	logic [CW-1:0]                    cnt_q;
	logic signed [W-1:0]              x_q, y_q;
	logic signed [tcf_pkg::Z_W-1:0]   z_q;
	logic signed [W-1:0]              xs, ys, x0, y0, dx, dy, x_nx, y_nx;
	logic signed [tcf_pkg::Z_W-1:0]   z0, z_nx, tab;

	always_comb begin
		xs = W'(x_in) <<< 16;
		ys = W'(y_in) <<< 16;
		if (xs < 0) begin
			if (ys >= 0) begin
				x0 = ys;
				y0 = -xs;
				z0 = tcf_pkg::Z_PLUS_90;
			end else begin
				x0 = -ys;
				y0 = xs;
				z0 = tcf_pkg::Z_MINUS_90;
			end
		end else begin
			x0 = xs;
			y0 = ys;
			z0 = '0;
		end
	end

	always_comb begin
		dx = x_q >>> cnt_q;
		dy = y_q >>> cnt_q;
		tab = tcf_pkg::atan_tab(tcf_pkg::TAB_IW'(cnt_q));
		if (y_q > 0) begin
			x_nx = x_q + dy;
			y_nx = y_q - dx;
			z_nx = z_q + tab;
		end else begin
			x_nx = x_q - dy;
			y_nx = y_q + dx;
			z_nx = z_q - tab;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x0;
			y_q    <= y0;
			z_q    <= z0;
			zero_q <= (x_in == '0) && (y_in == '0);
		end else if (busy_q) begin
			x_q <= x_nx;
			y_q <= y_nx;
			z_q <= z_nx;
		end
	end

	assign done  = done_q;
	assign z_out = zero_q ? '0 : z_q;

endmodule

// ===== rtl/tcf_blend.sv =====
// Three-stage blend of the gyro-propagated angle with the CORDIC angle; holds the angle state.
// Uses tcf_pkg for widths; the saturation limits are local parameters.
module tcf_blend (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [tcf_pkg::Z_W-1:0]     acc_in,
	input  logic signed [tcf_pkg::RD_W-1:0]    rd_in,
	input  logic [tcf_pkg::CFG_W-1:0]          weight,
	output logic                               done,
	output logic signed [tcf_pkg::ANGLE_W-1:0] angle
);
	localparam int unsigned PROP_W = tcf_pkg::RD_W;
	localparam int unsigned PA_W = PROP_W + tcf_pkg::CFG_W + 1;
	localparam int unsigned PB_W = tcf_pkg::Z_W + tcf_pkg::CFG_W + 2;
	localparam int unsigned MIX_W = PA_W + 1;
	localparam int unsigned R_W = MIX_W - 24;
	localparam logic signed [MIX_W-1:0] ROUND = MIX_W'(1) <<< 23;
	localparam logic signed [R_W-1:0] R_MAX = R_W'(8388607);
	localparam logic signed [R_W-1:0] R_MIN = -R_W'(8388608);

	logic                                 v_s1, v_s2, done_q;
	logic signed [PROP_W-1:0]             prop_s1;
	logic signed [tcf_pkg::Z_W-1:0]       acc_s1;
	logic signed [PA_W-1:0]               pa_s2;
	logic signed [PB_W-1:0]               pb_s2;
	logic signed [tcf_pkg::ANGLE_W-1:0]   angle_q;
	logic [tcf_pkg::CFG_W:0]              inv_w;
	logic signed [MIX_W-1:0]              mix;
	logic signed [R_W-1:0]                r;
	logic signed [tcf_pkg::ANGLE_W-1:0]   r_sat;

	assign inv_w = (tcf_pkg::CFG_W + 1)'(1 << tcf_pkg::CFG_W) - {1'b0, weight};

	always_comb begin
		mix = MIX_W'(pa_s2) + MIX_W'(pb_s2) + ROUND;
		r = mix[MIX_W-1:24];
		if (r > R_MAX) begin
			r_sat = tcf_pkg::ANGLE_W'(R_MAX);
		end else if (r < R_MIN) begin
			r_sat = tcf_pkg::ANGLE_W'(R_MIN);
		end else begin
			r_sat = tcf_pkg::ANGLE_W'(r);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done_q  <= 1'b0;
			angle_q <= '0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			done_q <= v_s2;
			if (v_s2) begin
				angle_q <= r_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prop_s1 <= (PROP_W'(angle_q) <<< 8) + (rd_in >>> 4);
			acc_s1  <= acc_in;
		end
		if (v_s1) begin
			pa_s2 <= $signed({1'b0, weight}) * prop_s1;
			pb_s2 <= $signed({1'b0, inv_w}) * acc_s1;
		end
	end

	assign done  = done_q;
	assign angle = angle_q;

endmodule

// ===== rtl/tcf_lane.sv =====
// One filter lane: gyro increment product, CORDIC atan2 and blend for one angle.
// Uses tcf_pkg, tcf_cordic and tcf_blend.
module tcf_lane #(
	parameter int unsigned CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [tcf_pkg::IN_W:0]      num,
	input  logic signed [tcf_pkg::IN_W-1:0]    den,
	input  logic signed [tcf_pkg::IN_W-1:0]    rate,
	input  tcf_pkg::lane_cfg_t                 cfg,
	output logic                               done,
	output logic signed [tcf_pkg::ANGLE_W-1:0] angle
);
	logic signed [tcf_pkg::RD_W-1:0] rd_q;
	logic signed [tcf_pkg::Z_W-1:0]  acc;
	logic                            cordic_done;

	always_ff @(posedge clk) begin
		if (start) begin
			rd_q <= rate * $signed({1'b0, cfg.period});
		end
	end

	tcf_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.y_in  (num),
		.x_in  (den),
		.done  (cordic_done),
		.z_out (acc)
	);

	tcf_blend u_blend (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cordic_done),
		.acc_in(acc),
		.rd_in (rd_q),
		.weight(cfg.weight),
		.done  (done),
		.angle (angle)
	);

endmodule

// ===== rtl/tcf_checker.sv =====
// Port-level checks for the tilt filter, bound to the top level.
// Uses tcf_pkg types and assert_macros.svh.
`include "assert_macros.svh"

module tcf_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      sample_valid,
	input logic                      sample_ready,
	input logic                      angle_valid,
	input logic                      angle_ready,
	input tcf_pkg::angles_t          angles
);
	`ASSERT_CLK(a_out_hold, angle_valid && !angle_ready |=> angle_valid, "result item dropped")
	`ASSERT_CLK(a_out_stable, angle_valid && !angle_ready |=> $stable(angles), "result item changed")
	`ASSERT_CLK(a_busy, sample_valid && sample_ready |=> !sample_ready ##1 !sample_ready ##1 !sample_ready, "item taken while busy")
	`ASSERT_ALWAYS(a_rst_empty, !arst_n |=> !angle_valid, "result item during reset")

endmodule

bind tilt_complementary_filter tcf_checker u_tcf_checker (.*);
